>>> sv/cht_pkg.sv
// cht_pkg: shared widths, codes and control/status types of the chained hash table
// used by cht_ctrl, cht_dpath and the top level chained_hash_table
`timescale 1ns / 1ps

package cht_pkg;

    localparam int MAX_BUCKETS_DEF = 16;
    localparam int CHAIN_DEPTH_DEF = 8;

    localparam int CMD_W    = 1;
    localparam int KM_W     = 24;
    localparam int YEAR_W   = 12;
    localparam int BRAND_W  = 64;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = KM_W + YEAR_W + BRAND_W;
    localparam int TDATA_W  = ((ENTRY_W + 7) / 8) * 8;

    localparam int BCNT_W = 5;
    localparam logic [BCNT_W-1:0] BCNT_RESET = 5'd10;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [0:0] REG_BUCKET_COUNT = 1'b0;

    // remainder unit retires two key bits per cycle
    localparam int DIV_STEPS = KM_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [CMD_W-1:0] CMD_INSERT = 1'b0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic start;
        logic div_step;
        logic fill_rd;
        logic decide;
        logic scan;
        logic out_load;
    } cht_cmd_t;

    typedef struct packed {
        logic div_last;
        logic need_scan;
        logic scan_done;
        logic out_free;
    } cht_stat_t;

endpackage

>>> sv/cht_ram.sv
// cht_ram: generic simple dual-port ram, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps

module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/cht_ctrl.sv
// cht_ctrl: sequencing state machine of the chained hash table
// uses cht_pkg command and status types, drives cht_dpath
`timescale 1ns / 1ps

module cht_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  cht_pkg::cht_stat_t stat,
    output cht_pkg::cht_cmd_t  cmd
);
    import cht_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DIV    = 3'd1;
    localparam logic [2:0] S_FILL   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_SCAN   = 3'd4;
    localparam logic [2:0] S_WAIT   = 3'd5;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = S_FILL;
                end
            end
            S_FILL: begin
                cmd.fill_rd = 1'b1;
                state_next  = S_DECIDE;
            end
            S_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = stat.need_scan ? S_SCAN : S_WAIT;
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_done) begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> sv/cht_dpath.sv
// cht_dpath: request registers, remainder unit, fill and entry rams, chain scan, output register
// uses cht_pkg and cht_ram, commanded by cht_ctrl
`timescale 1ns / 1ps

module cht_dpath #(
    parameter int MAX_BUCKETS = cht_pkg::MAX_BUCKETS_DEF,
    parameter int CHAIN_DEPTH = cht_pkg::CHAIN_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cht_pkg::cht_cmd_t             cmd,
    output cht_pkg::cht_stat_t            stat,
    input  logic [cht_pkg::BCNT_W-1:0]    bucket_count,
    input  logic [cht_pkg::CMD_W-1:0]     in_cmd,
    input  logic [cht_pkg::KM_W-1:0]      in_km_key,
    input  logic [cht_pkg::YEAR_W-1:0]    in_year,
    input  logic [cht_pkg::BRAND_W-1:0]   in_brand,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [cht_pkg::STATUS_W-1:0]  out_status,
    output logic [cht_pkg::KM_W-1:0]      out_km,
    output logic [cht_pkg::YEAR_W-1:0]    out_year,
    output logic [cht_pkg::BRAND_W-1:0]   out_brand
);
    import cht_pkg::*;

    localparam int B_W    = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int D_W    = $clog2(MAX_BUCKETS + 1);
    localparam int IDX_W  = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
    localparam int FILL_W = $clog2(CHAIN_DEPTH + 1);
    localparam int SLOTS  = MAX_BUCKETS * CHAIN_DEPTH;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // request
    logic [CMD_W-1:0]   cmd_reg;
    logic [KM_W-1:0]    key_reg;
    logic [YEAR_W-1:0]  year_reg;
    logic [BRAND_W-1:0] brand_reg;

    // remainder unit
    logic [D_W-1:0]       divisor_reg, divisor_next;
    logic [D_W-1:0]       rem_reg, rem_next;
    logic [KM_W-1:0]      shift_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [D_W:0]         part_a, part_b;
    logic [D_W-1:0]       rem_a;

    logic [B_W-1:0]    bucket;
    logic [SLOT_W-1:0] base_reg;

    // fill counts
    logic [MAX_BUCKETS-1:0] fill_vld_reg;
    logic [FILL_W-1:0]      fill_rdata, fill_cur, fill_wdata;
    logic                   fill_we;

    // entry store and scan
    logic               ent_we, ent_re;
    logic [SLOT_W-1:0]  ent_waddr, ent_raddr;
    logic [ENTRY_W-1:0] ent_wdata, ent_rdata;
    logic [IDX_W-1:0]   idx_reg;
    logic               more_reg, pend_reg, last_reg;
    logic               hit, miss, full;

    // held result and output register
    logic [STATUS_W-1:0] res_status_reg;
    logic [ENTRY_W-1:0]  res_entry_reg;
    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [ENTRY_W-1:0]  m_entry_reg;

    always_comb begin
        if (bucket_count == '0) begin
            divisor_next = D_W'(1);
        end else if (32'(bucket_count) > MAX_BUCKETS) begin
            divisor_next = D_W'(MAX_BUCKETS);
        end else begin
            divisor_next = D_W'(bucket_count);
        end
    end

    // two restoring steps per cycle, remainder stays below the divisor
    always_comb begin
        part_a = {rem_reg, shift_reg[KM_W-1]};
        if (part_a >= {1'b0, divisor_reg}) begin
            part_a = part_a - {1'b0, divisor_reg};
        end
        rem_a  = part_a[D_W-1:0];
        part_b = {rem_a, shift_reg[KM_W-2]};
        if (part_b >= {1'b0, divisor_reg}) begin
            part_b = part_b - {1'b0, divisor_reg};
        end
        rem_next = part_b[D_W-1:0];
    end

    assign bucket = rem_reg[B_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            cmd_reg     <= in_cmd;
            key_reg     <= in_km_key;
            year_reg    <= in_year;
            brand_reg   <= in_brand;
            divisor_reg <= divisor_next;
            rem_reg     <= '0;
            shift_reg   <= in_km_key;
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg     <= rem_next;
            shift_reg   <= {shift_reg[KM_W-3:0], 2'b00};
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
        if (cmd.fill_rd) begin
            base_reg <= SLOT_W'(bucket) * SLOT_W'(CHAIN_DEPTH);
        end
    end

    cht_ram #(
        .WIDTH(FILL_W),
        .DEPTH(MAX_BUCKETS)
    ) u_fill_ram (
        .aclk (aclk),
        .we   (fill_we),
        .waddr(bucket),
        .wdata(fill_wdata),
        .re   (cmd.fill_rd),
        .raddr(bucket),
        .rdata(fill_rdata)
    );

    // a bucket never written reads as empty
    assign fill_cur   = fill_vld_reg[bucket] ? fill_rdata : '0;
    assign full       = (fill_cur >= FILL_W'(CHAIN_DEPTH));
    assign fill_we    = cmd.decide && (cmd_reg == CMD_INSERT) && !full;
    assign fill_wdata = fill_cur + FILL_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_vld_reg <= '0;
        end else if (fill_we) begin
            fill_vld_reg[bucket] <= 1'b1;
        end
    end

    assign ent_we    = fill_we;
    assign ent_waddr = base_reg + SLOT_W'(fill_cur);
    assign ent_wdata = {brand_reg, year_reg, key_reg};
    assign ent_re    = cmd.scan && more_reg;
    assign ent_raddr = base_reg + SLOT_W'(idx_reg);

    cht_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(SLOTS)
    ) u_entry_ram (
        .aclk (aclk),
        .we   (ent_we),
        .waddr(ent_waddr),
        .wdata(ent_wdata),
        .re   (ent_re),
        .raddr(ent_raddr),
        .rdata(ent_rdata)
    );

    // reads issue newest first, each compare falls in the cycle after its read issues
    assign hit  = pend_reg && (ent_rdata[KM_W-1:0] == key_reg);
    assign miss = pend_reg && last_reg && !hit;

    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            idx_reg  <= IDX_W'(fill_cur - FILL_W'(1));
            more_reg <= 1'b1;
            pend_reg <= 1'b0;
            last_reg <= 1'b0;
        end else if (cmd.scan) begin
            pend_reg <= more_reg;
            last_reg <= (idx_reg == '0);
            more_reg <= more_reg && (idx_reg != '0);
            idx_reg  <= idx_reg - IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            res_entry_reg <= '0;
            if (cmd_reg == CMD_INSERT) begin
                res_status_reg <= full ? ST_FULL : ST_INSERTED;
            end else begin
                res_status_reg <= ST_NOT_FOUND;
            end
        end else if (cmd.scan && hit) begin
            res_status_reg <= ST_FOUND;
            res_entry_reg  <= ent_rdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (out_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_status_reg <= res_status_reg;
            m_entry_reg  <= res_entry_reg;
        end
    end

    assign stat.div_last  = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign stat.need_scan = (cmd_reg == CMD_LOOKUP) && (fill_cur != '0);
    assign stat.scan_done = hit || miss;
    assign stat.out_free  = !m_valid_reg || out_ready;

    assign out_valid  = m_valid_reg;
    assign out_status = m_status_reg;
    assign out_km     = m_entry_reg[KM_W-1:0];
    assign out_year   = m_entry_reg[KM_W +: YEAR_W];
    assign out_brand  = m_entry_reg[KM_W+YEAR_W +: BRAND_W];

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> (divisor_reg != '0))
        else $error("remainder unit running with zero divisor");

    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fill_rd |-> (rem_reg < divisor_reg))
        else $error("bucket index not below bucket count");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_we |-> (fill_wdata <= FILL_W'(CHAIN_DEPTH)))
        else $error("chain fill count beyond chain depth");

    a_out_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !out_ready) |=> (m_valid_reg && $stable(m_status_reg)))
        else $error("pending result overwritten");

endmodule

>>> sv/chained_hash_table.sv
// chained_hash_table: top level, apb configuration register and stream ports
// depends on cht_pkg, cht_ctrl, cht_dpath (which uses cht_ram)
//
// Each request on the s_ channel is an insert (s_tuser = 0) or a lookup (s_tuser = 1) keyed
// by mileage; every request yields exactly one result on the m_ channel. The bucket is the
// key modulo bucket_count (apb address 0, 0 acts as 1, above MAX_BUCKETS acts as MAX_BUCKETS).
// An insert stores the entry at the head of its bucket chain or reports full when the chain
// holds CHAIN_DEPTH entries; a lookup returns the newest entry with the same key.
// From accept to m_tvalid a request passes the remainder unit (two key bits a cycle), the
// fill ram read and the decide step; a lookup of a non-empty bucket then scans its chain,
// newest entry first, with one entry-ram read a cycle, until it matches or the chain ends;
// the result then enters the output register. One request is processed at a time; a new
// request can be taken in the cycle after the previous result enters the output register.
// The output register lets the next request proceed while a result waits on m_tready; a
// stalled result blocks only at the point the next one needs the register.
// Reset clears the bucket fill valid bits (all chains empty), the output valid and sets
// bucket_count to 10; no clearing pass is needed, requests are accepted right after reset.
`timescale 1ns / 1ps

module chained_hash_table #(
    parameter int MAX_BUCKETS = cht_pkg::MAX_BUCKETS_DEF,
    parameter int CHAIN_DEPTH = cht_pkg::CHAIN_DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // s_tdata: km_key[23:0], year[35:24], brand[99:36], zero fill
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [cht_pkg::TDATA_W-1:0]  s_tdata,
    // s_tuser: cmd[0]
    input  logic [cht_pkg::CMD_W-1:0]    s_tuser,
    // m_tdata: found_km[23:0], found_year[35:24], found_brand[99:36], zero fill
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [cht_pkg::TDATA_W-1:0]  m_tdata,
    // m_tuser: status[1:0]
    output logic [cht_pkg::STATUS_W-1:0] m_tuser,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cht_pkg::APB_AW-1:0]   paddr,
    input  logic [cht_pkg::APB_DW-1:0]   pwdata,
    output logic [cht_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import cht_pkg::*;

    logic [BCNT_W-1:0]   bucket_count_reg;
    cht_cmd_t            cmd;
    cht_stat_t           stat;
    logic [KM_W-1:0]     out_km;
    logic [YEAR_W-1:0]   out_year;
    logic [BRAND_W-1:0]  out_brand;

    assign pready = 1'b1;

    // register index is the word address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bucket_count_reg <= BCNT_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_BUCKET_COUNT)) begin
            bucket_count_reg <= pwdata[BCNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_BUCKET_COUNT) ?
                    {{(APB_DW - BCNT_W){1'b0}}, bucket_count_reg} : '0;

    cht_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    cht_dpath #(
        .MAX_BUCKETS(MAX_BUCKETS),
        .CHAIN_DEPTH(CHAIN_DEPTH)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .bucket_count(bucket_count_reg),
        .in_cmd      (s_tuser),
        .in_km_key   (s_tdata[KM_W-1:0]),
        .in_year     (s_tdata[KM_W +: YEAR_W]),
        .in_brand    (s_tdata[KM_W+YEAR_W +: BRAND_W]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_status  (m_tuser),
        .out_km      (out_km),
        .out_year    (out_year),
        .out_brand   (out_brand)
    );

    assign m_tdata = {{(TDATA_W - ENTRY_W){1'b0}}, out_brand, out_year, out_km};

endmodule

>>> tb/chained_hash_table_test.sv
// chained_hash_table_test: self-checking bench for the chained hash table, stream ports plus apb
// depends on cht_pkg and chained_hash_table; keeps its own copy of the chains to predict replies
`timescale 1ns / 1ps

module chained_hash_table_test;
    import cht_pkg::*;

    localparam int BUCKETS = MAX_BUCKETS_DEF;
    localparam int DEPTH = CHAIN_DEPTH_DEF;
    localparam int ITEMS_PER_PHASE = 188;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PRESSURE_AFTER = 500;
    localparam int PRESSURE_CYCLES = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS = 10;
    localparam logic [APB_AW-1:0] ADDR_BUCKET_COUNT = {REG_BUCKET_COUNT, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_SPARE = 3'd4;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [KM_W-1:0]     km;
        logic [YEAR_W-1:0]   year;
        logic [BRAND_W-1:0]  brand;
    } reply_t;

    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic [KM_W-1:0]    key;
        logic [YEAR_W-1:0]  year;
        logic [BRAND_W-1:0] brand;
        bit                 fixed;
        reply_t             reply;
    } directed_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata;
    logic [CMD_W-1:0]     s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [TDATA_W-1:0]   m_tdata;
    logic [STATUS_W-1:0]  m_tuser;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    // shadow of the table contents
    logic [BCNT_W-1:0]  bucket_reg = BCNT_RESET;
    logic [KM_W-1:0]    slot_km    [BUCKETS*DEPTH];
    logic [YEAR_W-1:0]  slot_year  [BUCKETS*DEPTH];
    logic [BRAND_W-1:0] slot_brand [BUCKETS*DEPTH];
    int                 chain_len  [BUCKETS];

    reply_t          due_replies[$];
    directed_row_t   directed_rows[$];
    logic [KM_W-1:0] key_pool[$];
    int              mismatches = 0;
    int              replies_seen = 0;
    int              quiet_cycles = 0;
    int              send_burst = 0;

    chained_hash_table dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    function automatic reply_t apply_to_table(input logic [CMD_W-1:0] cmd,
                                              input logic [KM_W-1:0] key,
                                              input logic [YEAR_W-1:0] year,
                                              input logic [BRAND_W-1:0] brand);
        reply_t res;
        int divisor;
        int bucket;
        int base;
        int len;
        bit hit;
        res = '{default: '0};
        divisor = (bucket_reg == 0) ? 1 : ((bucket_reg > BUCKETS) ? BUCKETS : int'(bucket_reg));
        bucket = int'(key) % divisor;
        base = bucket * DEPTH;
        len = chain_len[bucket];
        hit = 1'b0;
        if (cmd == CMD_INSERT) begin
            if (len >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                slot_km[base+len] = key;
                slot_year[base+len] = year;
                slot_brand[base+len] = brand;
                chain_len[bucket] = len + 1;
                res.status = ST_INSERTED;
            end
        end else begin
            res.status = ST_NOT_FOUND;
            // newest entry sits at the top of the chain
            for (int i = len - 1; i >= 0 && !hit; i--) begin
                if (slot_km[base+i] == key) begin
                    hit = 1'b1;
                    res.status = ST_FOUND;
                    res.km = slot_km[base+i];
                    res.year = slot_year[base+i];
                    res.brand = slot_brand[base+i];
                end
            end
        end
        return res;
    endfunction

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic flag_mismatch(input string what, input logic [BRAND_W-1:0] want,
                                 input logic [BRAND_W-1:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch in %s at %0t: expected %h, got %h", what, $time, want, got);
    endtask

    task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [KM_W-1:0] key,
                           input logic [YEAR_W-1:0] year, input logic [BRAND_W-1:0] brand,
                           input bit fixed, input logic [STATUS_W-1:0] status,
                           input logic [KM_W-1:0] km, input logic [YEAR_W-1:0] yr,
                           input logic [BRAND_W-1:0] br);
        directed_row_t row;
        row.cmd = cmd;
        row.key = key;
        row.year = year;
        row.brand = brand;
        row.fixed = fixed;
        row.reply.status = status;
        row.reply.km = km;
        row.reply.year = yr;
        row.reply.brand = br;
        directed_rows.push_back(row);
    endtask

    // called at a falling edge, returns at the falling edge after the request is taken
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [KM_W-1:0] key,
                                input logic [YEAR_W-1:0] year, input logic [BRAND_W-1:0] brand,
                                input bit fixed, input reply_t fixed_reply);
        reply_t predicted;
        int gap;
        if (send_burst > 0) begin
            send_burst--;
            gap = 0;
        end else if ($urandom_range(0, 99) < 5) begin
            send_burst = $urandom_range(20, 60);
            gap = 0;
        end else begin
            gap = idle_length();
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= TDATA_W'({brand, year, key});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = apply_to_table(cmd, key, year, brand);
        due_replies.push_back(fixed ? fixed_reply : predicted);
        @(negedge aclk);
    endtask

    task automatic drain_replies();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (due_replies.size() != 0) @(negedge aclk);
    endtask

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (addr == ADDR_BUCKET_COUNT)
            bucket_reg = data[BCNT_W-1:0];
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic check_bucket_count();
        logic [APB_DW-1:0] got;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_BUCKET_COUNT;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        got = prdata;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (got[BCNT_W-1:0] !== bucket_reg)
            flag_mismatch("bucket_count readback", BRAND_W'(bucket_reg),
                          BRAND_W'(got[BCNT_W-1:0]));
    endtask

    // reply checker
    always @(posedge aclk) begin
        reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            replies_seen++;
            if (due_replies.size() == 0) begin
                flag_mismatch("reply with no request pending", '0, BRAND_W'(m_tuser));
            end else begin
                want = due_replies.pop_front();
                if (m_tuser !== want.status)
                    flag_mismatch("status", BRAND_W'(want.status), BRAND_W'(m_tuser));
                if (m_tdata[KM_W-1:0] !== want.km)
                    flag_mismatch("found_km", BRAND_W'(want.km), BRAND_W'(m_tdata[KM_W-1:0]));
                if (m_tdata[KM_W+YEAR_W-1:KM_W] !== want.year)
                    flag_mismatch("found_year", BRAND_W'(want.year),
                                  BRAND_W'(m_tdata[KM_W+YEAR_W-1:KM_W]));
                if (m_tdata[ENTRY_W-1:KM_W+YEAR_W] !== want.brand)
                    flag_mismatch("found_brand", want.brand, m_tdata[ENTRY_W-1:KM_W+YEAR_W]);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // result side back-pressure
    initial begin
        int run;
        bit pressured;
        pressured = 1'b0;
        m_tready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (!pressured && replies_seen >= PRESSURE_AFTER) begin
                // long hold so the block backs up into its input
                pressured = 1'b1;
                m_tready <= 1'b0;
                repeat (PRESSURE_CYCLES) @(negedge aclk);
            end else if ($urandom_range(0, 99) < 5) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(30, 80)) @(negedge aclk);
            end else begin
                run = idle_length();
                if (run > 0) begin
                    m_tready <= 1'b0;
                    repeat (run) @(negedge aclk);
                end
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 4)) @(negedge aclk);
            end
        end
    end

    initial begin
        int                 phase_counts[10];
        logic [CMD_W-1:0]   cmd;
        logic [KM_W-1:0]    key;
        logic [YEAR_W-1:0]  year;
        logic [BRAND_W-1:0] brand;
        logic [APB_DW-1:0]  wdata;
        reply_t             none;
        int                 pick;

        phase_counts = '{1, 0, 16, 31, 17, 2, 7, 13, 16, 10};
        none = '{default: '0};
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        foreach (chain_len[b])
            chain_len[b] = 0;

        // bucket_count is 10 after reset
        add_row(CMD_LOOKUP, 24'd0, 12'd0, 64'd0, 1, ST_NOT_FOUND, 24'd0, 12'd0, 64'd0);
        add_row(CMD_INSERT, 24'd0, 12'd0, 64'd0, 1, ST_INSERTED, 24'd0, 12'd0, 64'd0);
        add_row(CMD_INSERT, 24'hFFFFFF, 12'hFFF, '1, 1, ST_INSERTED, 24'd0, 12'd0, 64'd0);
        add_row(CMD_LOOKUP, 24'hFFFFFF, 12'd0, 64'd0, 1, ST_FOUND, 24'hFFFFFF, 12'hFFF, '1);
        add_row(CMD_LOOKUP, 24'd0, 12'hFFF, '1, 1, ST_FOUND, 24'd0, 12'd0, 64'd0);
        add_row(CMD_INSERT, 24'd10, 12'd2001, 64'h0000_006E_6164_6573, 1, ST_INSERTED,
                24'd0, 12'd0, 64'd0);
        // duplicate key, lookup must return the newer one
        add_row(CMD_INSERT, 24'd0, 12'd5, 64'h0000_006E_6F67_6177, 1, ST_INSERTED,
                24'd0, 12'd0, 64'd0);
        add_row(CMD_LOOKUP, 24'd0, 12'd0, 64'd0, 0, ST_FOUND, 24'd0, 12'd0, 64'd0);
        add_row(CMD_LOOKUP, 24'd20, 12'd0, 64'd0, 1, ST_NOT_FOUND, 24'd0, 12'd0, 64'd0);
        // fill one chain to the limit, then one more
        for (int k = 0; k < DEPTH; k++)
            add_row(CMD_INSERT, KM_W'(3 + 10 * k), YEAR_W'(1990 + k), BRAND_W'(k + 1), 1,
                    ST_INSERTED, 24'd0, 12'd0, 64'd0);
        add_row(CMD_INSERT, 24'd83, 12'd7, 64'd7, 1, ST_FULL, 24'd0, 12'd0, 64'd0);
        add_row(CMD_LOOKUP, 24'd3, 12'd0, 64'd0, 0, ST_FOUND, 24'd0, 12'd0, 64'd0);
        add_row(CMD_LOOKUP, 24'd73, 12'd0, 64'd0, 0, ST_FOUND, 24'd0, 12'd0, 64'd0);
        add_row(CMD_LOOKUP, 24'd93, 12'd0, 64'd0, 1, ST_NOT_FOUND, 24'd0, 12'd0, 64'd0);
        add_row(CMD_INSERT, 24'hAAAAAA, 12'hAAA, {4{16'hAAAA}}, 1, ST_INSERTED,
                24'd0, 12'd0, 64'd0);
        add_row(CMD_LOOKUP, 24'h555555, 12'h555, {4{16'h5555}}, 0, ST_NOT_FOUND,
                24'd0, 12'd0, 64'd0);

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        check_bucket_count();

        foreach (directed_rows[r])
            send_request(directed_rows[r].cmd, directed_rows[r].key, directed_rows[r].year,
                         directed_rows[r].brand, directed_rows[r].fixed,
                         directed_rows[r].reply);

        foreach (phase_counts[p]) begin
            drain_replies();
            if (p == 0) begin
                // write to an unused address must leave bucket_count alone
                apb_write(ADDR_SPARE, $urandom);
                check_bucket_count();
            end
            wdata = $urandom;
            wdata[BCNT_W-1:0] = BCNT_W'(phase_counts[p]);
            apb_write(ADDR_BUCKET_COUNT, wdata);
            check_bucket_count();
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                cmd = ($urandom_range(0, 99) < 45) ? CMD_INSERT : CMD_LOOKUP;
                pick = $urandom_range(0, 99);
                if (key_pool.size() > 0 && pick < ((cmd == CMD_LOOKUP) ? 65 : 30))
                    key = key_pool[$urandom_range(0, key_pool.size() - 1)];
                else if (pick < 85)
                    key = KM_W'($urandom_range(0, 63));
                else
                    key = KM_W'($urandom);
                if (cmd == CMD_INSERT)
                    key_pool.push_back(key);
                year = YEAR_W'($urandom);
                brand = {$urandom, $urandom};
                send_request(cmd, key, year, brand, 1'b0, none);
            end
        end

        drain_replies();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0 && due_replies.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
